FILE: design/sedd_pkg.sv
package sedd_pkg;

   localparam int SEDD_WIDTH_DEFAULT = 1024;

   // stored error and the weighted error parts
   typedef logic signed [7:0] err_type;
   typedef logic signed [5:0] part_type;

   // transaction command and kernel direction codes
   typedef enum logic [1:0] {
      CMD_PIXEL     = 2'd0,
      CMD_NEXT_ROW  = 2'd1,
      CMD_CLEAR_ALL = 2'd2,
      CMD_UNUSED    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      DIR_PARITY = 2'd0,
      DIR_LTR    = 2'd1,
      DIR_RTL    = 2'd2,
      DIR_UNUSED = 2'd3
   } dir_type;

   // quantizer thresholds and output levels
   localparam logic [7:0] Q_THR1 = 8'd43;
   localparam logic [7:0] Q_THR2 = 8'd128;
   localparam logic [7:0] Q_THR3 = 8'd213;
   localparam logic [7:0] Q_LVL1 = 8'd85;
   localparam logic [7:0] Q_LVL2 = 8'd170;
   localparam logic [7:0] Q_LVL3 = 8'd255;

   // add a part into a stored error, saturating at the 8-bit signed range
   function automatic err_type sat_add(input err_type e, input part_type d);
      logic signed [8:0] s;
      s = 9'(e) + 9'(d);
      if (s > 9'sd127) begin
         return err_type'(8'sd127);
      end else if (s < -9'sd128) begin
         return err_type'(-8'sd128);
      end else begin
         return err_type'(s[7:0]);
      end
   endfunction

endpackage

FILE: design/sedd_row_mem.sv
module sedd_row_mem import sedd_pkg::*; #(
   parameter int DEPTH = SEDD_WIDTH_DEFAULT + 2,
   parameter int AW    = $clog2(SEDD_WIDTH_DEFAULT + 2)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  err_type       wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output err_type       rd_data
);

   err_type mem_ff [DEPTH];
   err_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/sedd_kernel.sv
module sedd_kernel import sedd_pkg::*; (
   input  logic [7:0] gray,
   input  err_type    err_in,
   output logic [1:0] level,
   output part_type   part7,
   output part_type   part3,
   output part_type   part5,
   output part_type   part1
);

   logic signed [9:0] sum;
   logic [7:0]        adj;
   logic [7:0]        qval;
   logic signed [8:0] err9;
   logic signed [9:0] e10;
   logic signed [9:0] m7;
   logic signed [9:0] m3;
   logic signed [9:0] m5;

   always_comb begin
      sum = 10'(signed'({1'b0, gray})) + 10'(err_in);
      if (sum < 10'sd0) begin
         adj = 8'd0;
      end else if (sum > 10'sd255) begin
         adj = 8'd255;
      end else begin
         adj = sum[7:0];
      end

      priority if (adj < Q_THR1) begin
         level = 2'd0;
         qval  = 8'd0;
      end else if (adj < Q_THR2) begin
         level = 2'd1;
         qval  = Q_LVL1;
      end else if (adj < Q_THR3) begin
         level = 2'd2;
         qval  = Q_LVL2;
      end else begin
         level = 2'd3;
         qval  = Q_LVL3;
      end

      // error stays within -42..42
      err9 = signed'({1'b0, adj}) - signed'({1'b0, qval});
      e10  = 10'(err9);
      m7   = e10 * 10'sd7;
      m3   = e10 * 10'sd3;
      m5   = e10 * 10'sd5;
      // arithmetic shift gives the floor of the division by 16
      part7 = part_type'(m7 >>> 4);
      part3 = part_type'(m3 >>> 4);
      part5 = part_type'(m5 >>> 4);
      part1 = part_type'(e10 >>> 4);
   end

endmodule

FILE: design/serpentine_error_diffusion_dither.sv
// Serpentine Floyd-Steinberg dither of 8-bit gray pixels to four levels.
// Error for the current and the next row lives in two single-port-read,
// single-port-write memories of WIDTH+2 entries that swap roles on each
// next-row command. After a pixel transaction is accepted req_ready stays
// low through its read, quantize, write and done states, so a pixel is
// only taken once the last one is through: a read of the current row feeds
// the quantizer, and the three read-modify-writes into the next row share
// the one read and one write port of that memory. The result is registered,
// so a finished pixel waits on rsp_ready without holding up the memory
// work; the sequence only waits in its done state while an earlier result
// has not been taken yet. Next-row and clear-all transactions give no
// result; each clears its memory with a sweep over all WIDTH+2 entries
// during which req_ready is low. After reset the same clearing pass runs
// before the first transaction is taken. A pixel whose column is at or
// beyond WIDTH, and the unused command code, are accepted and dropped.
module serpentine_error_diffusion_dither import sedd_pkg::*; #(
   parameter int WIDTH = SEDD_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_command,
   input  logic [7:0] req_gray,
   input  logic [9:0] req_column,
   input  logic [1:0] req_direction,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_level,
   output logic       rsp_reversed_used
);

   localparam int SLOTS = WIDTH + 2;
   localparam int AW    = $clog2(SLOTS);

   typedef enum logic [2:0] {
      ST_SWEEP, ST_IDLE, ST_READ, ST_QUANT, ST_W1, ST_W2, ST_W3, ST_DONE
   } state_type;

   state_type     state_ff;
   logic [AW-1:0] cnt_ff;
   logic          clr_a_ff;
   logic          clr_b_ff;
   logic          cur_sel_ff;
   logic          parity_ff;
   logic [AW-1:0] x_ff;
   logic [7:0]    gray_ff;
   logic          rev_ff;
   logic [1:0]    level_ff;
   part_type      p7_ff;
   part_type      p3_ff;
   part_type      p5_ff;
   part_type      p1_ff;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_level_ff;
   logic          rsp_rev_ff;

   logic [AW-1:0] x1;
   logic [AW-1:0] x2;
   logic [AW-1:0] addr_a0;
   logic [AW-1:0] addr_a2;
   part_type      part_a0;
   part_type      part_a2;

   logic          cur_re, cur_we, nxt_re, nxt_we;
   logic [AW-1:0] cur_raddr, cur_waddr, nxt_raddr, nxt_waddr;
   err_type       cur_wdata, nxt_wdata;
   err_type       cur_rdata, nxt_rdata;

   logic          a_we, a_re, b_we, b_re;
   logic [AW-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
   err_type       a_wdata, b_wdata, a_rdata, b_rdata;

   logic [1:0]    k_level;
   part_type      k_p7, k_p3, k_p5, k_p1;
   logic          req_fire;
   logic          in_range;
   logic          req_rev;

   assign req_ready         = (state_ff == ST_IDLE);
   assign req_fire          = req_valid && req_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_level         = rsp_level_ff;
   assign rsp_reversed_used = rsp_rev_ff;

   assign in_range = int'(req_column) < WIDTH;
   assign req_rev  = (req_direction == DIR_RTL) ? 1'b1 :
                     (req_direction == DIR_LTR) ? 1'b0 : parity_ff;

   // entry c+1 belongs to column c
   assign x1      = x_ff + AW'(1);
   assign x2      = x_ff + AW'(2);
   assign addr_a0 = rev_ff ? x2 : x_ff;
   assign addr_a2 = rev_ff ? x_ff : x2;
   // the 3/16 part lands behind the pixel in scan order, the 1/16 part ahead
   assign part_a0 = p3_ff;
   assign part_a2 = p1_ff;

   assign cur_rdata = cur_sel_ff ? b_rdata : a_rdata;
   assign nxt_rdata = cur_sel_ff ? a_rdata : b_rdata;

   sedd_kernel u_kernel (
      .gray   (gray_ff),
      .err_in (cur_rdata),
      .level  (k_level),
      .part7  (k_p7),
      .part3  (k_p3),
      .part5  (k_p5),
      .part1  (k_p1)
   );

   // per-pixel read-modify-write sequence on the two row stores
   always_comb begin
      cur_re    = 1'b0;
      cur_raddr = x1;
      cur_we    = 1'b0;
      cur_waddr = addr_a2;
      cur_wdata = sat_add(cur_rdata, p7_ff);
      nxt_re    = 1'b0;
      nxt_raddr = addr_a0;
      nxt_we    = 1'b0;
      nxt_waddr = addr_a0;
      nxt_wdata = sat_add(nxt_rdata, part_a0);
      unique case (state_ff)
         ST_READ: begin
            cur_re = 1'b1;
            nxt_re = 1'b1;
         end
         ST_QUANT: begin
            cur_re    = 1'b1;
            cur_raddr = addr_a2;
         end
         ST_W1: begin
            cur_we    = 1'b1;
            nxt_we    = 1'b1;
            nxt_re    = 1'b1;
            nxt_raddr = x1;
         end
         ST_W2: begin
            nxt_we    = 1'b1;
            nxt_waddr = x1;
            nxt_wdata = sat_add(nxt_rdata, p5_ff);
            nxt_re    = 1'b1;
            nxt_raddr = addr_a2;
         end
         ST_W3: begin
            nxt_we    = 1'b1;
            nxt_waddr = addr_a2;
            nxt_wdata = sat_add(nxt_rdata, part_a2);
         end
         default: begin
         end
      endcase
   end

   // map the logical stores onto the two memories
   always_comb begin
      if (state_ff == ST_SWEEP) begin
         a_we    = clr_a_ff;
         a_waddr = cnt_ff;
         a_wdata = '0;
         a_re    = 1'b0;
         a_raddr = cnt_ff;
         b_we    = clr_b_ff;
         b_waddr = cnt_ff;
         b_wdata = '0;
         b_re    = 1'b0;
         b_raddr = cnt_ff;
      end else if (!cur_sel_ff) begin
         a_we    = cur_we;
         a_waddr = cur_waddr;
         a_wdata = cur_wdata;
         a_re    = cur_re;
         a_raddr = cur_raddr;
         b_we    = nxt_we;
         b_waddr = nxt_waddr;
         b_wdata = nxt_wdata;
         b_re    = nxt_re;
         b_raddr = nxt_raddr;
      end else begin
         a_we    = nxt_we;
         a_waddr = nxt_waddr;
         a_wdata = nxt_wdata;
         a_re    = nxt_re;
         a_raddr = nxt_raddr;
         b_we    = cur_we;
         b_waddr = cur_waddr;
         b_wdata = cur_wdata;
         b_re    = cur_re;
         b_raddr = cur_raddr;
      end
   end

   sedd_row_mem #(.DEPTH(SLOTS), .AW(AW)) u_mem_a (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_en   (a_re),
      .rd_addr (a_raddr),
      .rd_data (a_rdata)
   );

   sedd_row_mem #(.DEPTH(SLOTS), .AW(AW)) u_mem_b (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_en   (b_re),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         cnt_ff       <= '0;
         clr_a_ff     <= 1'b1;
         clr_b_ff     <= 1'b1;
         cur_sel_ff   <= 1'b0;
         parity_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in ST_DONE the result register is handled by the sequence itself
         if (rsp_valid_ff && rsp_ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_SWEEP: begin
               if (int'(cnt_ff) == SLOTS - 1) begin
                  state_ff <= ST_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + AW'(1);
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  unique case (req_command)
                     CMD_PIXEL: begin
                        if (in_range) begin
                           x_ff     <= AW'(req_column);
                           gray_ff  <= req_gray;
                           rev_ff   <= req_rev;
                           state_ff <= ST_READ;
                        end
                     end
                     CMD_NEXT_ROW: begin
                        // the old current row becomes the next row, cleared
                        cur_sel_ff <= ~cur_sel_ff;
                        parity_ff  <= ~parity_ff;
                        clr_a_ff   <= ~cur_sel_ff;
                        clr_b_ff   <= cur_sel_ff;
                        cnt_ff     <= '0;
                        state_ff   <= ST_SWEEP;
                     end
                     CMD_CLEAR_ALL: begin
                        parity_ff <= 1'b0;
                        clr_a_ff  <= 1'b1;
                        clr_b_ff  <= 1'b1;
                        cnt_ff    <= '0;
                        state_ff  <= ST_SWEEP;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_READ: begin
               state_ff <= ST_QUANT;
            end
            ST_QUANT: begin
               level_ff <= k_level;
               p7_ff    <= k_p7;
               p3_ff    <= k_p3;
               p5_ff    <= k_p5;
               p1_ff    <= k_p1;
               state_ff <= ST_W1;
            end
            ST_W1: begin
               state_ff <= ST_W2;
            end
            ST_W2: begin
               state_ff <= ST_W3;
            end
            ST_W3: begin
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_level_ff <= level_ff;
                  rsp_rev_ff   <= rev_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // a result only appears at the end of a pixel sequence
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the pixel sequence");

   // the store roles never swap while a pixel is being worked on
   a_sel_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_SWEEP) |=> $stable(cur_sel_ff))
      else $error("row store swapped during a pixel");

   // the clearing sweep stays inside the store
   a_sweep_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (int'(cnt_ff) < SLOTS))
      else $error("clearing sweep out of range");

endmodule

FILE: sim/serpentine_error_diffusion_dither_tb.sv
module serpentine_error_diffusion_dither_tb import sedd_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIX_WIDTH = SEDD_WIDTH_DEFAULT;
   localparam int SLOTS = PIX_WIDTH + 2;

   typedef enum logic [1:0] {
      LVL_BLACK = 2'd0,
      LVL_DARK  = 2'd1,
      LVL_LIGHT = 2'd2,
      LVL_WHITE = 2'd3
   } level_type;

   typedef struct packed {
      level_type level;
      logic      reversed;
   } dither_out_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_command;
   logic [7:0] req_gray;
   logic [9:0] req_column;
   logic [1:0] req_direction;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_level;
   logic       rsp_reversed_used;

   // predictor state: two error rows that swap roles, plus the row parity
   err_type        err_mem [2][SLOTS];
   bit             cur_sel;
   bit             row_parity_m;
   dither_out_type level_q [$];
   dither_out_type exp_out;

   int unsigned req_idle_max;
   int unsigned rsp_idle_max;
   int unsigned hold_request;
   bit          rsp_taken;

   int unsigned errors;
   int unsigned pixels_sent;
   int unsigned rows_advanced;
   int unsigned clears_sent;
   int unsigned ignored_sent;
   int unsigned results_checked;

   serpentine_error_diffusion_dither #(
      .WIDTH(PIX_WIDTH)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_gray         (req_gray),
      .req_column       (req_column),
      .req_direction    (req_direction),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_level        (rsp_level),
      .rsp_reversed_used(rsp_reversed_used)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #15_000_000;
      $display("timeout: %0d results still expected", level_q.size());
      $display("== FAIL ==");
      $finish;
   end

   task automatic report_mismatch(input string what);
      errors++;
      $display("%0t mismatch: %s", $realtime, what);
   endtask

   function automatic void sat_store(input bit sel, input int slot, input int delta);
      int s;
      s = int'(err_mem[sel][slot]) + delta;
      if (s > 127) s = 127;
      else if (s < -128) s = -128;
      err_mem[sel][slot] = err_type'(s);
   endfunction

   function automatic void clear_row(input bit sel);
      for (int i = 0; i < SLOTS; i++) err_mem[sel][i] = '0;
   endfunction

   // state update for one accepted transaction, queues the expected pixel result
   function automatic void diffuse_txn(input cmd_type cmd, input logic [7:0] gray,
                                       input logic [9:0] col, input dir_type dir);
      int             x, adj, qval, err;
      bit             rev;
      bit             nxt;
      dither_out_type r;
      case (cmd)
         CMD_NEXT_ROW: begin
            cur_sel = !cur_sel;
            clear_row(!cur_sel);
            row_parity_m = !row_parity_m;
         end
         CMD_CLEAR_ALL: begin
            clear_row(1'b0);
            clear_row(1'b1);
            row_parity_m = 1'b0;
         end
         CMD_PIXEL: begin
            if (int'(col) < PIX_WIDTH) begin
               x = int'(col);
               if (dir == DIR_LTR) rev = 1'b0;
               else if (dir == DIR_RTL) rev = 1'b1;
               else rev = row_parity_m;
               adj = int'(gray) + int'(err_mem[cur_sel][x + 1]);
               if (adj < 0) adj = 0;
               if (adj > 255) adj = 255;
               if (adj < int'(Q_THR1)) begin
                  r.level = LVL_BLACK;
                  qval = 0;
               end else if (adj < int'(Q_THR2)) begin
                  r.level = LVL_DARK;
                  qval = int'(Q_LVL1);
               end else if (adj < int'(Q_THR3)) begin
                  r.level = LVL_LIGHT;
                  qval = int'(Q_LVL2);
               end else begin
                  r.level = LVL_WHITE;
                  qval = int'(Q_LVL3);
               end
               err = adj - qval;
               nxt = !cur_sel;
               // >>> on a signed int is a floor division by 16
               if (!rev) begin
                  sat_store(cur_sel, x + 2, (err * 7) >>> 4);
                  sat_store(nxt, x, (err * 3) >>> 4);
                  sat_store(nxt, x + 1, (err * 5) >>> 4);
                  sat_store(nxt, x + 2, err >>> 4);
               end else begin
                  sat_store(cur_sel, x, (err * 7) >>> 4);
                  sat_store(nxt, x + 2, (err * 3) >>> 4);
                  sat_store(nxt, x + 1, (err * 5) >>> 4);
                  sat_store(nxt, x, err >>> 4);
               end
               r.reversed = rev;
               level_q.push_back(r);
            end
         end
         default: ;
      endcase
   endfunction

   // one transaction on the request side, valid held until accepted
   task automatic drive_txn(input cmd_type cmd, input logic [7:0] gray,
                            input logic [9:0] col, input dir_type dir);
      int unsigned gap;
      gap = $urandom_range(0, req_idle_max);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_gray      <= gray;
      req_column    <= col;
      req_direction <= dir;
      do @(posedge clock); while (!req_ready);
      diffuse_txn(cmd, gray, col, dir);
      case (cmd)
         CMD_PIXEL:     pixels_sent++;
         CMD_NEXT_ROW:  rows_advanced++;
         CMD_CLEAR_ALL: clears_sent++;
         default:       ignored_sent++;
      endcase
   endtask

   task automatic send_pixel(input logic [7:0] gray, input logic [9:0] col,
                             input dir_type dir);
      drive_txn(CMD_PIXEL, gray, col, dir);
   endtask

   task automatic send_cmd(input cmd_type cmd);
      drive_txn(cmd, 8'($urandom), 10'($urandom), dir_type'($urandom_range(0, 3)));
   endtask

   // receiver: random stall after each result, or one long hold when asked
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end else if (rsp_taken) begin
            stall_left = $urandom_range(0, rsp_idle_max);
         end
         rsp_taken = 1'b0;
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_taken = 1'b1;
         results_checked++;
         if (level_q.size() == 0) begin
            report_mismatch($sformatf("result with no pixel pending (level %0d rev %0d)",
                                      rsp_level, rsp_reversed_used));
         end else begin
            exp_out = level_q.pop_front();
            if (rsp_level !== exp_out.level)
               report_mismatch($sformatf("level %0d, expected %0d", rsp_level, exp_out.level));
            if (rsp_reversed_used !== exp_out.reversed)
               report_mismatch($sformatf("reversed_used %0d, expected %0d",
                                         rsp_reversed_used, exp_out.reversed));
         end
      end
   end

   task automatic test_directed_edges();
      req_idle_max = 3;
      rsp_idle_max = 3;
      send_cmd(CMD_CLEAR_ALL);
      send_pixel(8'd0, 10'd0, DIR_LTR);
      send_pixel(8'd255, 10'd1023, DIR_RTL);
      send_pixel(8'd255, 10'd1022, DIR_LTR);
      // values on both sides of each threshold
      send_pixel(8'd42, 10'd100, DIR_LTR);
      send_pixel(8'd43, 10'd200, DIR_LTR);
      send_pixel(8'd127, 10'd300, DIR_RTL);
      send_pixel(8'd128, 10'd400, DIR_RTL);
      send_pixel(8'd212, 10'd500, DIR_LTR);
      send_pixel(8'd213, 10'd600, DIR_LTR);
      send_pixel(8'd128, 10'd50, DIR_PARITY);
      send_pixel(8'd90, 10'd49, DIR_UNUSED);
      send_cmd(CMD_NEXT_ROW);
      // odd row: parity now picks the mirrored kernel
      send_pixel(8'd100, 10'd51, DIR_PARITY);
      send_pixel(8'd200, 10'd1, DIR_UNUSED);
      send_pixel(8'd170, 10'd2, DIR_LTR);
      send_cmd(CMD_UNUSED);
      send_cmd(CMD_NEXT_ROW);
      send_pixel(8'd60, 10'd3, DIR_PARITY);
      send_cmd(CMD_CLEAR_ALL);
      send_pixel(8'd100, 10'd51, DIR_PARITY);
   endtask

   task automatic test_saturation();
      req_idle_max = 1;
      rsp_idle_max = 1;
      send_cmd(CMD_CLEAR_ALL);
      // positive error piles up in one slot until it sticks at 127
      repeat (8) send_pixel(8'd42, 10'd5, DIR_LTR);
      send_pixel(8'd128, 10'd6, DIR_LTR);
      // negative error sticks at -128, then the next pixel clamps to zero
      repeat (7) send_pixel(8'd43, 10'd20, DIR_RTL);
      send_pixel(8'd0, 10'd19, DIR_RTL);
      send_cmd(CMD_NEXT_ROW);
      send_pixel(8'd128, 10'd5, DIR_PARITY);
      send_pixel(8'd10, 10'd21, DIR_PARITY);
   endtask

   task automatic test_random_rows(input int unsigned pixel_goal, input int unsigned req_max,
                                   input int unsigned rsp_max);
      int unsigned done_pix, span, start, pick, c;
      logic [7:0]  g;
      dir_type     d;
      req_idle_max = req_max;
      rsp_idle_max = rsp_max;
      done_pix = 0;
      while (done_pix < pixel_goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            // a row segment walked in the serpentine order of the current row
            span = $urandom_range(2, 16);
            case ($urandom_range(0, 7))
               0: start = 0;
               1: start = PIX_WIDTH - span;
               default: start = $urandom_range(0, PIX_WIDTH - span);
            endcase
            for (int k = 0; k < span; k++) begin
               c = row_parity_m ? start + span - 1 - k : start + k;
               case ($urandom_range(0, 7))
                  0: g = 8'd0;
                  1: g = 8'd255;
                  default: g = 8'($urandom);
               endcase
               d = ($urandom_range(0, 9) == 0) ? dir_type'($urandom_range(0, 3))
                                               : DIR_PARITY;
               send_pixel(g, 10'(c), d);
               done_pix++;
            end
            send_cmd(CMD_NEXT_ROW);
         end else if (pick < 84) begin
            send_cmd(CMD_CLEAR_ALL);
         end else if (pick < 89) begin
            send_cmd(CMD_UNUSED);
         end else begin
            send_pixel(8'($urandom), 10'($urandom), dir_type'($urandom_range(0, 3)));
            done_pix++;
         end
      end
   endtask

   task automatic test_output_backpressure();
      req_idle_max = 0;
      rsp_idle_max = 0;
      hold_request = 200;
      for (int k = 0; k < 20; k++) send_pixel(8'($urandom), 10'(300 + k), DIR_PARITY);
      send_cmd(CMD_NEXT_ROW);
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_command   = CMD_PIXEL;
      req_gray      = '0;
      req_column    = '0;
      req_direction = DIR_PARITY;
      rsp_ready     = 1'b0;
      rsp_taken     = 1'b0;
      hold_request  = 0;
      req_idle_max  = 0;
      rsp_idle_max  = 0;
      cur_sel       = 1'b0;
      row_parity_m  = 1'b0;
      clear_row(1'b0);
      clear_row(1'b1);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_saturation();
      test_random_rows(200, 3, 3);
      test_output_backpressure();
      test_random_rows(120, 0, 0);
      test_random_rows(150, 0, 3);

      @(negedge clock);
      req_valid <= 1'b0;
      while (level_q.size() != 0) @(posedge clock);
      // a trailing row sweep may still be running
      repeat (PIX_WIDTH + 20) @(posedge clock);

      $display("covered %0d pixels, %0d row advances, %0d clears, %0d unused commands",
               pixels_sent, rows_advanced, clears_sent, ignored_sent);
      $display("%0d results compared, %0d mismatches", results_checked, errors);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: files.f
design/sedd_pkg.sv
design/sedd_row_mem.sv
design/sedd_kernel.sv
design/serpentine_error_diffusion_dither.sv
sim/serpentine_error_diffusion_dither_tb.sv
